// File: hdl/tbhvc_pkg.sv
// Shared types and constants for the take-back-half velocity controller.
// No dependencies; the channel interfaces and the top level import it.
`timescale 1ns / 1ps

package tbhvc_pkg;

  // Field widths of the tick and result items
  localparam int TARGET_W = 10;
  localparam int MEAS_W   = 11;
  localparam int OUT_W    = 7;

  // Gain register: unsigned Q0.24
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 24;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd4194;

  // Speed error spans -1023..2047, so 12 bits signed and 11 bits of magnitude
  localparam int ERR_W = 12;
  localparam int MAG_W = 11;

  // Seed = target * 127 / 600 in Q7.f; 600 = 75 * 8
  localparam int SEED_MUL       = 127;
  localparam int SEED_DEN_Q     = 75;
  localparam int SEED_DEN_SHIFT = 3;
  localparam int SEED_PROD_W    = 17;
  localparam int SEED_QUOT_W    = 10;
  localparam int SEED_REM_W     = 7;
  localparam int SEED_RECIP_W   = 18;
  localparam logic [SEED_RECIP_W-1:0] SEED_RECIP = 18'd223697;
  localparam int SEED_RECIP_SHIFT = 24;
  localparam logic [TARGET_W-1:0] SEED_MAX_TARGET = 10'd600;

  // Full-scale drive, integer part
  localparam int FULL_INT = 127;

endpackage

// File: hdl/tbhvc_tick_if.sv
// Input channel of the take-back-half velocity controller: one control tick per item.
// Depends on tbhvc_pkg for field widths.
`timescale 1ns / 1ps

interface tbhvc_tick_if
  import tbhvc_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic                       enable;
  logic [TARGET_W-1:0]        target_speed;
  logic signed [MEAS_W-1:0]   measured_speed;

  modport source (output valid, output enable, output target_speed,
                  output measured_speed, input ready);
  modport sink   (input valid, input enable, input target_speed,
                  input measured_speed, output ready);
endinterface

// File: hdl/tbhvc_result_if.sv
// Output channel of the take-back-half velocity controller: one result item per enabled tick.
// Depends on tbhvc_pkg for field widths.
`timescale 1ns / 1ps

interface tbhvc_result_if
  import tbhvc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] drive;
  logic [OUT_W-1:0] estimate;
  logic             crossed;

  modport source (output valid, output drive, output estimate, output crossed,
                  input ready);
  modport sink   (input valid, input drive, input estimate, input crossed,
                  output ready);
endinterface

// File: hdl/take_back_half_velocity_control.sv
// Take-back-half flywheel speed controller, top level.
// Depends on tbhvc_pkg, tbhvc_tick_if and tbhvc_result_if.
//
// Usage:
//   tick   : valid/ready channel carrying enable, target_speed (RPM) and
//            measured_speed (RPM, two's complement). An item is taken on a
//            clock edge where valid and ready are both high.
//   result : valid/ready channel carrying drive, estimate (integer parts of
//            the Q7.FRAC_BITS accumulators) and crossed.
//   cfg_we / cfg_data : write the integral gain (unsigned Q0.24) while idle.
// Ticks with enable low are consumed and produce no result.
// Throughput: one item per clock unless the result side stalls. A tick goes
// through s1 and s2 into the result register. The first register stage
// forms the seed (reciprocal multiply by 1/75 plus a 75-entry fraction
// table) and the gain product; the second applies step, clamp and
// take-back-half update to the controller state and loads the result
// register. A stall on the result side freezes all three stages and drops
// tick.ready; nothing is lost. Reset clears the controller state (with the
// first-crossing flag set), empties the pipeline and loads the default gain.
`timescale 1ns / 1ps

module take_back_half_velocity_control
  import tbhvc_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [GAIN_W-1:0]     cfg_data,
  tbhvc_tick_if.sink            tick,
  tbhvc_result_if.source        result
);

  localparam int DW        = FRAC_BITS + OUT_W;
  localparam int UpShift   = (FRAC_BITS >= GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
  localparam int DnShift   = (FRAC_BITS < GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;
  localparam int ProdW     = GAIN_W + MAG_W;
  localparam int StepW     = ProdW + UpShift;
  localparam int SumW      = ((StepW > DW) ? StepW : DW) + 1;
  localparam int SeedShift = FRAC_BITS - SEED_DEN_SHIFT;
  localparam int RecipW    = SEED_PROD_W + SEED_RECIP_W;
  localparam logic [DW-1:0] FullScale = DW'(FULL_INT) << FRAC_BITS;

  // Configuration
  logic [GAIN_W-1:0] gain;

  // Pipeline control
  logic advance;

  // Stage 1: captured tick
  logic                     s1_valid;
  logic [TARGET_W-1:0]      s1_target;
  logic signed [MEAS_W-1:0] s1_meas;

  // Stage 1 combinational
  logic signed [ERR_W-1:0]  error;
  logic                     err_neg;
  logic [ERR_W-1:0]         mag_w;
  logic [MAG_W-1:0]         mag;
  logic [ProdW-1:0]         gain_prod;
  logic [StepW-1:0]         step;
  logic [SEED_PROD_W-1:0]   seed_x;
  logic [RecipW-1:0]        recip_prod;
  logic [SEED_QUOT_W-1:0]   seed_q;
  logic [SEED_PROD_W-1:0]   seed_rem_w;
  logic [SEED_REM_W-1:0]    seed_rem;
  logic [SeedShift-1:0]     frac_tab [SEED_DEN_Q];
  logic [DW-1:0]            seed;

  // Stage 2: prepared item
  logic                 s2_valid;
  logic [TARGET_W-1:0]  s2_target;
  logic [DW-1:0]        s2_seed;
  logic [StepW-1:0]     s2_step;
  logic                 s2_neg;

  // Controller state
  logic [DW-1:0]        drive_acc;
  logic [DW-1:0]        hold_estimate;
  logic [TARGET_W-1:0]  previous_target;
  logic                 previous_error_negative;
  logic                 first_crossing;

  // Stage 2 combinational
  logic                 target_new;
  logic [DW-1:0]        acc0;
  logic [DW-1:0]        est0;
  logic                 first0;
  logic [SumW-1:0]      acc0_w;
  logic [SumW-1:0]      step_w;
  logic [SumW-1:0]      acc1_w;
  logic [DW-1:0]        acc1;
  logic [DW:0]          mean_w;
  logic                 crossed_now;
  logic [DW-1:0]        drive_acc_next;
  logic [DW-1:0]        hold_estimate_next;
  logic                 first_crossing_next;

  assign advance    = !result.valid || result.ready;
  assign tick.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_data;
    end
  end

  // Fraction of the seed quotient: floor(r * 2^SeedShift / 75) for each remainder
  for (genvar gi = 0; gi < SEED_DEN_Q; gi++) begin : g_frac
    localparam logic [63:0] FracVal = (64'(gi) << SeedShift) / SEED_DEN_Q;
    assign frac_tab[gi] = FracVal[SeedShift-1:0];
  end

  always_comb begin
    error     = $signed({2'b00, s1_target}) - ERR_W'(s1_meas);
    err_neg   = error[ERR_W-1];
    mag_w     = err_neg ? ERR_W'(-error) : ERR_W'(error);
    mag       = mag_w[MAG_W-1:0];
    gain_prod = ProdW'(gain) * ProdW'(mag);
    step      = (StepW'(gain_prod) << UpShift) >> DnShift;

    // x = target * 127; x / 75 by reciprocal multiply, exact for all 17-bit x used
    seed_x     = (SEED_PROD_W'(s1_target) << 7) - SEED_PROD_W'(s1_target);
    recip_prod = RecipW'(seed_x) * RecipW'(SEED_RECIP);
    seed_q     = SEED_QUOT_W'(recip_prod >> SEED_RECIP_SHIFT);
    seed_rem_w = seed_x - SEED_PROD_W'(seed_q) * SEED_PROD_W'(SEED_DEN_Q);
    seed_rem   = seed_rem_w[SEED_REM_W-1:0];
    if (s1_target > SEED_MAX_TARGET) begin
      seed = FullScale;
    end else begin
      seed = (DW'(seed_q) << SeedShift) | DW'(frac_tab[seed_rem]);
    end
  end

  always_comb begin
    target_new = s2_target != previous_target;
    acc0       = target_new ? s2_seed : drive_acc;
    est0       = target_new ? s2_seed : hold_estimate;
    first0     = target_new || first_crossing;

    acc0_w = SumW'(acc0);
    step_w = SumW'(s2_step);
    if (s2_neg) begin
      acc1_w = (step_w > acc0_w) ? '0 : acc0_w - step_w;
    end else begin
      acc1_w = acc0_w + step_w;
    end
    acc1 = (acc1_w > SumW'(FullScale)) ? FullScale : acc1_w[DW-1:0];

    mean_w      = {1'b0, acc1} + {1'b0, est0};
    crossed_now = s2_neg != previous_error_negative;

    drive_acc_next      = acc1;
    hold_estimate_next  = est0;
    first_crossing_next = first0;
    if (crossed_now) begin
      if (first0) begin
        drive_acc_next      = est0;
        first_crossing_next = 1'b0;
      end else begin
        drive_acc_next = mean_w[DW:1];
      end
      hold_estimate_next = drive_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid                <= 1'b0;
      s2_valid                <= 1'b0;
      result.valid            <= 1'b0;
      drive_acc               <= '0;
      hold_estimate           <= '0;
      previous_target         <= '0;
      previous_error_negative <= 1'b0;
      first_crossing          <= 1'b1;
    end else if (advance) begin
      // Disabled ticks drop out here
      s1_valid     <= tick.valid && tick.enable;
      s2_valid     <= s1_valid;
      result.valid <= s2_valid;
      if (s2_valid) begin
        drive_acc               <= drive_acc_next;
        hold_estimate           <= hold_estimate_next;
        previous_target         <= s2_target;
        previous_error_negative <= s2_neg;
        first_crossing          <= first_crossing_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_target       <= tick.target_speed;
      s1_meas         <= tick.measured_speed;
      s2_target       <= s1_target;
      s2_seed         <= seed;
      s2_step         <= step;
      s2_neg          <= err_neg;
      result.drive    <= drive_acc_next[DW-1:FRAC_BITS];
      result.estimate <= hold_estimate_next[DW-1:FRAC_BITS];
      result.crossed  <= crossed_now;
    end
  end

  a_drive_in_range : assert property (@(posedge clk) disable iff (rst)
    drive_acc <= FullScale)
    else $error("drive accumulator above full scale");

  a_estimate_in_range : assert property (@(posedge clk) disable iff (rst)
    hold_estimate <= FullScale)
    else $error("estimate above full scale");

  a_cross_matches : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.crossed |-> result.drive == result.estimate)
    else $error("crossing result with drive different from estimate");

  a_stage_to_result : assert property (@(posedge clk) disable iff (rst)
    s2_valid && advance |=> result.valid)
    else $error("prepared item did not reach the result register");

endmodule

// File: sim/testbench.sv
// Self-checking bench for the take-back-half velocity controller.
// Needs tbhvc_pkg, tbhvc_tick_if, tbhvc_result_if and the top level; it mirrors
// the controller state to predict each result and checks results in order.
`timescale 1ns / 1ps

module testbench
  import tbhvc_pkg::*;
;
  localparam int FRAC        = 24;
  localparam int ACC_W       = FRAC + 7;
  localparam int DRAIN_WAIT  = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] FULL_SCALE = 64'(FULL_INT) << FRAC;
  localparam int SEED_DEN = SEED_DEN_Q << SEED_DEN_SHIFT;

  typedef struct packed {
    logic [OUT_W-1:0] drive;
    logic [OUT_W-1:0] estimate;
    logic             crossed;
  } drive_report_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [GAIN_W-1:0] cfg_data;

  tbhvc_tick_if   tick_ch ();
  tbhvc_result_if result_ch ();

  take_back_half_velocity_control #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .tick    (tick_ch),
    .result  (result_ch)
  );

  // Mirrored controller state, reset values
  logic [ACC_W-1:0]    ctl_drive         = '0;
  logic [ACC_W-1:0]    ctl_estimate      = '0;
  logic [TARGET_W-1:0] ctl_last_target   = '0;
  bit                  ctl_last_negative = 1'b0;
  bit                  ctl_first_cross   = 1'b1;
  logic [GAIN_W-1:0]   ctl_gain          = GAIN_RESET;

  drive_report_t pending_reports[$];
  int            fault_count     = 0;
  int            cycle_count     = 0;
  int            hold_request    = 0;
  int            hold_left       = 0;
  bit            sender_steady   = 1'b0;
  bit            receiver_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[take_back_half_velocity_control] ERROR");
        $finish;
      end
    end
  end

  // One enabled tick of the take-back-half law; queue the result it owes
  function automatic void tbh_control_step(input logic [TARGET_W-1:0] target,
                                           input logic signed [MEAS_W-1:0] measured);
    int            speed_error;
    bit            err_negative;
    bit            crossed;
    logic [63:0]   err_mag;
    logic [63:0]   gain_step;
    logic [63:0]   acc;
    logic [63:0]   seed;
    drive_report_t report;
    acc = 64'(ctl_drive);
    if (target != ctl_last_target) begin
      seed = ((64'(target) * SEED_MUL) << FRAC) / SEED_DEN;
      if (seed > FULL_SCALE) seed = FULL_SCALE;
      ctl_estimate    = seed[ACC_W-1:0];
      ctl_first_cross = 1'b1;
      acc             = seed;
    end
    ctl_last_target = target;

    speed_error  = int'(target) - int'(measured);
    err_negative = speed_error < 0;
    err_mag      = err_negative ? 64'(-speed_error) : 64'(speed_error);
    gain_step    = 64'(ctl_gain) * err_mag;
    if (FRAC >= GAIN_FRAC) gain_step = gain_step << (FRAC - GAIN_FRAC);
    else gain_step = gain_step >> (GAIN_FRAC - FRAC);

    if (err_negative) acc = (gain_step > acc) ? 64'd0 : acc - gain_step;
    else acc = acc + gain_step;
    if (acc > FULL_SCALE) acc = FULL_SCALE;

    crossed = err_negative != ctl_last_negative;
    if (crossed) begin
      if (ctl_first_cross) begin
        acc             = 64'(ctl_estimate);
        ctl_first_cross = 1'b0;
      end else begin
        acc = (acc + 64'(ctl_estimate)) >> 1;
      end
      ctl_estimate = acc[ACC_W-1:0];
    end
    ctl_last_negative = err_negative;
    ctl_drive         = acc[ACC_W-1:0];

    report.drive    = OUT_W'(acc >> FRAC);
    report.estimate = OUT_W'(ctl_estimate >> FRAC);
    report.crossed  = crossed;
    pending_reports.push_back(report);
  endfunction

  // Offer one item; return at the edge that takes it
  task automatic send_tick(input bit en, input int target, input int speed);
    bit taken;
    if (!sender_steady) begin
      while ($urandom_range(99) < 36) begin
        tick_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    tick_ch.valid          <= 1'b1;
    tick_ch.enable         <= en;
    tick_ch.target_speed   <= target[TARGET_W-1:0];
    tick_ch.measured_speed <= speed[MEAS_W-1:0];
    do begin
      @(negedge clk);
      taken = tick_ch.ready;
      @(posedge clk);
    end while (!taken);
    if (en) tbh_control_step(target[TARGET_W-1:0], speed[MEAS_W-1:0]);
  endtask

  // Hold the sender until every owed result is back and the pipe is empty
  task automatic settle_pipeline();
    tick_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] value);
    settle_pipeline();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ctl_gain = value;
  endtask

  task automatic note_fault(input string field, input int want, input int got);
    fault_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // Receiver: random stalls, a long hold-off on request, or steady flow
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (receiver_steady) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= 36);
      end
    end
  end

  // Both handshake signals are stable from the falling edge to the next rising one
  initial begin : check_results
    drive_report_t want;
    forever begin
      @(negedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (pending_reports.size() == 0) begin
          fault_count++;
          $error("unexpected result: drive %0d estimate %0d crossed %0d",
                 result_ch.drive, result_ch.estimate, result_ch.crossed);
        end else begin
          want = pending_reports.pop_front();
          if (result_ch.drive !== want.drive)
            note_fault("drive", want.drive, result_ch.drive);
          if (result_ch.estimate !== want.estimate)
            note_fault("estimate", want.estimate, result_ch.estimate);
          if (result_ch.crossed !== want.crossed)
            note_fault("crossed", want.crossed, result_ch.crossed);
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_tick(1'b0, 1023, -1024);   // disabled: no result
    send_tick(1'b1, 0, 0);          // zero error counts as non-negative
    send_tick(1'b1, 0, 1023);       // first crossing takes the estimate
    send_tick(1'b1, 0, -1024);      // later crossing takes the mean
    send_tick(1'b1, 600, 600);      // seed lands exactly on full scale
    send_tick(1'b1, 601, 0);        // seed saturates, drive clamps high
    send_tick(1'b1, 1023, -1024);   // largest positive error
    send_tick(1'b1, 1023, 1023);
    send_tick(1'b1, 1, 1023);       // large negative error clamps at zero
    send_tick(1'b1, 300, 0);
    send_tick(1'b1, 300, 200);
    send_tick(1'b1, 300, 350);
    send_tick(1'b1, 300, 250);
    send_tick(1'b0, 5, 7);
    send_tick(1'b1, 300, 320);
    send_tick(1'b1, 300, 301);
    send_tick(1'b1, 300, 300);
    send_tick(1'b1, 300, 299);
    send_tick(1'b1, 341, -683);     // alternating bit patterns
    send_tick(1'b1, 682, 682);
    send_tick(1'b1, 512, -1);
    send_tick(1'b1, 511, 1024);
  endtask

  task automatic test_gain_extremes();
    write_gain('0);
    send_tick(1'b1, 500, 100);
    send_tick(1'b1, 500, 900);
    send_tick(1'b1, 500, 500);
    send_tick(1'b1, 20, 20);
    write_gain({GAIN_W{1'b1}});
    send_tick(1'b1, 200, -1024);
    send_tick(1'b1, 200, 1023);
    send_tick(1'b1, 200, -1024);
    send_tick(1'b1, 0, 1023);
    send_tick(1'b1, 0, -1);
    send_tick(1'b1, 1023, -1024);
    write_gain(24'd1);
    send_tick(1'b1, 700, 0);
    send_tick(1'b1, 700, 1023);
    send_tick(1'b1, 700, 0);
    write_gain(GAIN_RESET);
  endtask

  task automatic test_result_backpressure();
    sender_steady = 1'b1;
    hold_request  = 150;
    repeat (40)
      send_tick($urandom_range(9) != 0, $urandom_range(1023), $urandom_range(2047));
    sender_steady = 1'b0;
    settle_pipeline();
    repeat (20)
      send_tick(1'b1, 450, int'($urandom_range(100)) + 400);
    settle_pipeline();
  endtask

  // Runs at a held target with the speed settling around it, plus noise items
  task automatic test_random_sequences();
    logic [GAIN_W-1:0] phase_gain;
    int enabled_sent;
    int target;
    int speed;
    int run_len;
    bit en;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: phase_gain = GAIN_RESET;
        1: phase_gain = GAIN_W'($urandom_range(1, 20000));
        2: phase_gain = {GAIN_W{1'b1}};
        3: phase_gain = GAIN_W'($urandom_range(2000, 12000));
        4: phase_gain = GAIN_W'($urandom);
        5: phase_gain = '0;
        default: phase_gain = GAIN_W'($urandom_range(1, 200000));
      endcase
      write_gain(phase_gain);
      sender_steady   = (phase == 3);
      receiver_steady = (phase == 3);
      enabled_sent    = 0;
      while (enabled_sent < 220) begin
        if ($urandom_range(99) < 15) begin
          en = $urandom_range(99) < 80;
          send_tick(en, $urandom_range(1023), $urandom_range(2047));
          if (en) enabled_sent++;
        end else begin
          case ($urandom_range(3))
            0: target = $urandom_range(60);
            1: target = $urandom_range(560, 640);
            default: target = $urandom_range(1023);
          endcase
          speed   = $urandom_range(target);
          run_len = $urandom_range(8, 48);
          repeat (run_len) begin
            if ($urandom_range(99) < 5) begin
              send_tick(1'b0, $urandom_range(1023), $urandom_range(2047));
            end else begin
              speed = speed + (target - speed) / 2 + int'($urandom_range(60)) - 30;
              if (speed > 1023) speed = 1023;
              if (speed < -1024) speed = -1024;
              // break the run now and then with a stray target
              if ($urandom_range(99) < 3) send_tick(1'b1, $urandom_range(1023), speed);
              else send_tick(1'b1, target, speed);
              enabled_sent++;
            end
          end
        end
      end
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_data               <= '0;
    tick_ch.valid          <= 1'b0;
    tick_ch.enable         <= 1'b0;
    tick_ch.target_speed   <= '0;
    tick_ch.measured_speed <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_gain_extremes();
    test_result_backpressure();
    test_random_sequences();
    settle_pipeline();

    if (fault_count == 0) begin
      $display("[take_back_half_velocity_control] OK");
    end else begin
      $display("[take_back_half_velocity_control] ERROR");
    end
    $finish;
  end

endmodule
